>>> src/cps_pkg.sv
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types and codes for the cpu process scheduler block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cps_pkg;

  // input beat commands
  localparam logic [1:0] CMD_APPEND  = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  // scheduling policies
  localparam logic [2:0] MODE_FCFS = 3'd0;
  localparam logic [2:0] MODE_RR   = 3'd1;
  localparam logic [2:0] MODE_SJF  = 3'd2;
  localparam logic [2:0] MODE_SRTF = 3'd3;
  localparam logic [2:0] MODE_HRRN = 3'd4;

  // register indexes
  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADM_RD,
    ST_ADM_CHK,
    ST_PICK,
    ST_RR_PRE,
    ST_POP_RD,
    ST_POP_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_MUL_A,
    ST_MUL_B,
    ST_CMP,
    ST_EX_RD,
    ST_EX_WR,
    ST_OUT
  } state_t;

endpackage

>>> src/cps_tables.sv
// ----------------------------------------------------------------------------
// cps_tables
// Arrival, burst and remaining time memories with one shared registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cps_tables #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          entry_we,
  input  logic [AW-1:0] entry_addr,
  input  logic [DW-1:0] entry_arr,
  input  logic [DW-1:0] entry_bur,
  input  logic          rem_we,
  input  logic [AW-1:0] rem_addr,
  input  logic [DW-1:0] rem_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] q_arr,
  output logic [DW-1:0] q_bur,
  output logic [DW-1:0] q_rem
);

  logic [DW-1:0] arr_mem [DEPTH];
  logic [DW-1:0] bur_mem [DEPTH];
  logic [DW-1:0] rem_mem [DEPTH];

  // entry writes from the append command, remaining time writes from a run
  always_ff @(posedge clk) begin
    if (entry_we) begin
      arr_mem[entry_addr] <= entry_arr;
      bur_mem[entry_addr] <= entry_bur;
    end
    if (rem_we) begin
      rem_mem[rem_addr] <= rem_data;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_arr <= arr_mem[rd_addr];
      q_bur <= bur_mem[rd_addr];
      q_rem <= rem_mem[rd_addr];
    end
  end

endmodule

>>> src/cpu_process_scheduler_core.sv
// ----------------------------------------------------------------------------
// cpu_process_scheduler_core
// Time-unit scheduler over a process table: fcfs, round robin, sjf, srtf, hrrn.
// ----------------------------------------------------------------------------
// channel   dir  ports                                      beat
// input     in   in_valid/in_ready, in_cmd, in_arrival_time  one command
//                in_burst_time
// result    out  out_valid/out_ready, out_tick_time ...      one per tick
// config    in   psel/penable/pwrite/paddr/pwdata/prdata     one register
//
// append, restart and clear give no result beat.
// a tick reads pending entries in order for admission, then scans each
// admitted slot (in hrrn, one shared multiplier forms both cross products),
// or pops the queue in round robin, then updates the chosen slot and
// reports. the scan goes through the table memory's single read port.
// reset is synchronous; the table memories are not cleared.
// a stalled result holds the block in its report state; in_ready stays low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu_process_scheduler_core
  import cps_pkg::*;
#(
  parameter int MAX_PROCESSES = 16,
  parameter int TIME_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_arrival_time,
  input  logic [15:0] in_burst_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_tick_time,
  output logic [3:0]  out_running_slot,
  output logic        out_idle,
  output logic        out_finished,
  output logic [16:0] out_finish_time,
  output logic [16:0] out_turnaround,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW = $clog2(MAX_PROCESSES);
  localparam int CW = $clog2(MAX_PROCESSES + 1);
  localparam int TW = TIME_BITS;
  localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};
  localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_PROCESSES - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_PROCESSES);

  // configuration registers
  logic [2:0]  mode_r;
  logic [15:0] quantum_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_FCFS;
      quantum_r <= 16'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_MODE:    mode_r    <= pwdata[2:0];
        REG_QUANTUM: quantum_r <= pwdata[15:0];
        default:     mode_r    <= mode_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE:    prdata = {29'd0, mode_r};
      REG_QUANTUM: prdata = {16'd0, quantum_r};
      default:     prdata = 32'd0;
    endcase
  end

  // control and run state
  state_t          state_r, state_nxt;
  logic [CW-1:0]   entry_cnt_r, entry_cnt_nxt;
  logic [CW-1:0]   adm_cnt_r, adm_cnt_nxt;
  logic [TW-1:0]   cur_time_r, cur_time_nxt;
  logic [15:0]     slice_r, slice_nxt;
  logic [SW-1:0]   holder_r, holder_nxt;
  logic            holder_vld_r, holder_vld_nxt;
  logic [SW-1:0]   head_r, head_nxt;
  logic [SW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   ring_cnt_r, ring_cnt_nxt;
  logic [MAX_PROCESSES-1:0] done_r, done_nxt;
  logic [MAX_PROCESSES-1:0] remv_r, remv_nxt;

  // scan and execute working registers
  logic [CW-1:0]   scan_r, scan_nxt;
  logic            found_r, found_nxt;
  logic [SW-1:0]   best_r, best_nxt;
  logic [TW-1:0]   best_arr_r, best_arr_nxt;
  logic [TW-1:0]   best_bur_r, best_bur_nxt;
  logic [TW-1:0]   best_rem_r, best_rem_nxt;
  logic            run_r, run_nxt;
  logic [SW-1:0]   run_slot_r, run_slot_nxt;
  logic            fin_r, fin_nxt;
  logic [TW:0]     ft_r, ft_nxt;
  logic [TW:0]     ta_r, ta_nxt;
  logic [2*TW-1:0] prod_a_r, prod_a_nxt;
  logic [2*TW-1:0] prod_b_r, prod_b_nxt;

  // result register
  logic            out_valid_r, out_valid_nxt;
  logic [15:0]     o_time_r;
  logic [3:0]      o_slot_r;
  logic            o_idle_r;
  logic            o_fin_r;
  logic [16:0]     o_ft_r;
  logic [16:0]     o_ta_r;
  logic            out_load;

  // memory ports
  logic            entry_we;
  logic [TW-1:0]   entry_arr, entry_bur;
  logic            rem_we;
  logic [TW-1:0]   rem_data;
  logic            rd_en;
  logic [SW-1:0]   rd_addr;
  logic [TW-1:0]   q_arr, q_bur, q_rem;
  logic            ring_we;
  logic [SW-1:0]   ring_wdata;
  logic            ring_re;
  logic [SW-1:0]   ring_q;
  logic [SW-1:0]   ring_mem [MAX_PROCESSES];

  cps_tables #(
    .DEPTH (MAX_PROCESSES),
    .AW    (SW),
    .DW    (TW)
  ) u_tables (
    .clk        (clk),
    .entry_we   (entry_we),
    .entry_addr (entry_cnt_r[SW-1:0]),
    .entry_arr  (entry_arr),
    .entry_bur  (entry_bur),
    .rem_we     (rem_we),
    .rem_addr   (run_slot_r),
    .rem_data   (rem_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .q_arr      (q_arr),
    .q_bur      (q_bur),
    .q_rem      (q_rem)
  );

  // ready queue of slots for round robin
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[tail_r] <= ring_wdata;
    end
    if (ring_re) begin
      ring_q <= ring_mem[head_r];
    end
  end

  function automatic logic [SW-1:0] ptr_inc(input logic [SW-1:0] p);
    ptr_inc = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  // slot values seen through the read port
  logic [TW-1:0]   cand_rem;
  logic [TW-1:0]   cand_wait, best_wait;
  logic [TW-1:0]   mul_a, mul_b;
  logic [2*TW-1:0] mul_p;
  logic            hold_elig, pop_elig;
  logic [TW-1:0]   rem_new;
  logic [TW-1:0]   bur_in;

  assign cand_rem  = remv_r[scan_r[SW-1:0]] ? q_rem : q_bur;
  assign cand_wait = (q_arr <= cur_time_r) ? cur_time_r - q_arr : '0;
  assign best_wait = (best_arr_r <= cur_time_r) ? cur_time_r - best_arr_r : '0;
  assign hold_elig = (CW'(holder_r) < adm_cnt_r) && !done_r[holder_r];
  assign pop_elig  = (CW'(ring_q) < adm_cnt_r) && !done_r[ring_q];
  assign bur_in    = (TW'(in_burst_time) == '0) ? TW'(1) : TW'(in_burst_time);

  // shared multiplier for the hrrn cross products
  assign mul_a = (state_r == ST_MUL_A) ? cand_wait : best_wait;
  assign mul_b = (state_r == ST_MUL_A) ? best_bur_r : q_bur;
  assign mul_p = mul_a * mul_b;

  assign in_ready = (state_r == ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    entry_cnt_nxt  = entry_cnt_r;
    adm_cnt_nxt    = adm_cnt_r;
    cur_time_nxt   = cur_time_r;
    slice_nxt      = slice_r;
    holder_nxt     = holder_r;
    holder_vld_nxt = holder_vld_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    ring_cnt_nxt   = ring_cnt_r;
    done_nxt       = done_r;
    remv_nxt       = remv_r;
    scan_nxt       = scan_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_arr_nxt   = best_arr_r;
    best_bur_nxt   = best_bur_r;
    best_rem_nxt   = best_rem_r;
    run_nxt        = run_r;
    run_slot_nxt   = run_slot_r;
    fin_nxt        = fin_r;
    ft_nxt         = ft_r;
    ta_nxt         = ta_r;
    prod_a_nxt     = prod_a_r;
    prod_b_nxt     = prod_b_r;
    out_load       = 1'b0;
    entry_we       = 1'b0;
    entry_arr      = TW'(in_arrival_time);
    entry_bur      = bur_in;
    rem_we         = 1'b0;
    rem_new        = '0;
    rd_en          = 1'b0;
    rd_addr        = scan_r[SW-1:0];
    ring_we        = 1'b0;
    ring_wdata     = adm_cnt_r[SW-1:0];
    ring_re        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_APPEND: begin
              if (entry_cnt_r < FULL_CNT) begin
                entry_we = 1'b1;
                done_nxt[entry_cnt_r[SW-1:0]] = 1'b0;
                remv_nxt[entry_cnt_r[SW-1:0]] = 1'b0;
                entry_cnt_nxt = entry_cnt_r + 1'b1;
              end
            end
            CMD_TICK: begin
              state_nxt = ST_ADM_RD;
            end
            default: begin
              // restart, and clear which also empties the table
              if (in_cmd == CMD_CLEAR) entry_cnt_nxt = '0;
              done_nxt       = '0;
              remv_nxt       = '0;
              head_nxt       = '0;
              tail_nxt       = '0;
              ring_cnt_nxt   = '0;
              adm_cnt_nxt    = '0;
              cur_time_nxt   = '0;
              slice_nxt      = '0;
              holder_nxt     = '0;
              holder_vld_nxt = 1'b0;
            end
          endcase
        end
      end

      // admit arrivals in table order
      ST_ADM_RD: begin
        if (adm_cnt_r < entry_cnt_r) begin
          rd_en     = 1'b1;
          rd_addr   = adm_cnt_r[SW-1:0];
          state_nxt = ST_ADM_CHK;
        end else begin
          state_nxt = ST_PICK;
        end
      end

      ST_ADM_CHK: begin
        if (q_arr <= cur_time_r) begin
          if (mode_r == MODE_RR && ring_cnt_r < FULL_CNT) begin
            ring_we      = 1'b1;
            tail_nxt     = ptr_inc(tail_r);
            ring_cnt_nxt = ring_cnt_r + 1'b1;
          end
          adm_cnt_nxt = adm_cnt_r + 1'b1;
          state_nxt   = ST_ADM_RD;
        end else begin
          state_nxt = ST_PICK;
        end
      end

      // choose how this tick's slot is found
      ST_PICK: begin
        run_nxt   = 1'b0;
        found_nxt = 1'b0;
        scan_nxt  = '0;
        if (mode_r == MODE_RR) begin
          state_nxt = ST_RR_PRE;
        end else if (mode_r == MODE_SRTF) begin
          state_nxt = ST_SCAN_RD;
        end else if (holder_vld_r && hold_elig) begin
          run_nxt      = 1'b1;
          run_slot_nxt = holder_r;
          state_nxt    = ST_EX_RD;
        end else begin
          holder_vld_nxt = 1'b0;
          state_nxt      = ST_SCAN_RD;
        end
      end

      // round robin: requeue an expired holder, else keep it
      ST_RR_PRE: begin
        if (holder_vld_r && slice_r == '0) begin
          if (ring_cnt_r < FULL_CNT) begin
            ring_we      = 1'b1;
            ring_wdata   = holder_r;
            tail_nxt     = ptr_inc(tail_r);
            ring_cnt_nxt = ring_cnt_r + 1'b1;
          end
          holder_vld_nxt = 1'b0;
          state_nxt      = ST_POP_RD;
        end else if (holder_vld_r && hold_elig) begin
          run_nxt      = 1'b1;
          run_slot_nxt = holder_r;
          state_nxt    = ST_EX_RD;
        end else begin
          holder_vld_nxt = 1'b0;
          state_nxt      = ST_POP_RD;
        end
      end

      ST_POP_RD: begin
        if (ring_cnt_r != '0) begin
          ring_re      = 1'b1;
          head_nxt     = ptr_inc(head_r);
          ring_cnt_nxt = ring_cnt_r - 1'b1;
          state_nxt    = ST_POP_CHK;
        end else begin
          state_nxt = ST_OUT;
        end
      end

      ST_POP_CHK: begin
        if (pop_elig) begin
          run_nxt        = 1'b1;
          run_slot_nxt   = ring_q;
          holder_nxt     = ring_q;
          holder_vld_nxt = 1'b1;
          slice_nxt      = (quantum_r == '0) ? 16'd1 : quantum_r;
          state_nxt      = ST_EX_RD;
        end else begin
          state_nxt = ST_POP_RD;
        end
      end

      // scan admitted slots for the best candidate
      ST_SCAN_RD: begin
        if (scan_r < adm_cnt_r) begin
          rd_en     = 1'b1;
          state_nxt = ST_SCAN_CHK;
        end else if (found_r) begin
          run_nxt      = 1'b1;
          run_slot_nxt = best_r;
          if (mode_r != MODE_SRTF) begin
            holder_nxt     = best_r;
            holder_vld_nxt = 1'b1;
          end
          state_nxt = ST_EX_RD;
        end else begin
          state_nxt = ST_OUT;
        end
      end

      ST_SCAN_CHK: begin
        state_nxt = ST_SCAN_RD;
        scan_nxt  = scan_r + 1'b1;
        if (!done_r[scan_r[SW-1:0]]) begin
          if (!found_r ||
              (mode_r == MODE_SJF && q_bur < best_bur_r) ||
              (mode_r == MODE_SRTF && cand_rem < best_rem_r)) begin
            found_nxt    = 1'b1;
            best_nxt     = scan_r[SW-1:0];
            best_arr_nxt = q_arr;
            best_bur_nxt = q_bur;
            best_rem_nxt = cand_rem;
          end else if (mode_r == MODE_HRRN) begin
            scan_nxt  = scan_r;
            state_nxt = ST_MUL_A;
          end
        end
      end

      ST_MUL_A: begin
        prod_a_nxt = mul_p;
        state_nxt  = ST_MUL_B;
      end

      ST_MUL_B: begin
        prod_b_nxt = mul_p;
        state_nxt  = ST_CMP;
      end

      ST_CMP: begin
        if (prod_a_r > prod_b_r) begin
          best_nxt     = scan_r[SW-1:0];
          best_arr_nxt = q_arr;
          best_bur_nxt = q_bur;
          best_rem_nxt = cand_rem;
        end
        scan_nxt  = scan_r + 1'b1;
        state_nxt = ST_SCAN_RD;
      end

      // run the chosen slot for one time unit
      ST_EX_RD: begin
        rd_en     = 1'b1;
        rd_addr   = run_slot_r;
        state_nxt = ST_EX_WR;
      end

      ST_EX_WR: begin
        rem_new = remv_r[run_slot_r] ? q_rem : q_bur;
        if (rem_new != '0) rem_new = rem_new - 1'b1;
        rem_we = 1'b1;
        remv_nxt[run_slot_r] = 1'b1;
        if (slice_r != '0) slice_nxt = slice_r - 1'b1;
        fin_nxt = (rem_new == '0);
        ft_nxt  = {1'b0, cur_time_r} + 1'b1;
        ta_nxt  = {1'b0, cur_time_r} + 1'b1 - {1'b0, q_arr};
        if (rem_new == '0) begin
          done_nxt[run_slot_r] = 1'b1;
          if (holder_r == run_slot_r) holder_vld_nxt = 1'b0;
          slice_nxt = '0;
        end
        state_nxt = ST_OUT;
      end

      // report once the result register is free
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (cur_time_r < TIME_MAX) cur_time_nxt = cur_time_r + 1'b1;
          fin_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
    rem_data = rem_new;
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || out_load;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      entry_cnt_r  <= '0;
      adm_cnt_r    <= '0;
      cur_time_r   <= '0;
      slice_r      <= '0;
      holder_r     <= '0;
      holder_vld_r <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      ring_cnt_r   <= '0;
      done_r       <= '0;
      remv_r       <= '0;
      out_valid_r  <= 1'b0;
      run_r        <= 1'b0;
      fin_r        <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      entry_cnt_r  <= entry_cnt_nxt;
      adm_cnt_r    <= adm_cnt_nxt;
      cur_time_r   <= cur_time_nxt;
      slice_r      <= slice_nxt;
      holder_r     <= holder_nxt;
      holder_vld_r <= holder_vld_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      ring_cnt_r   <= ring_cnt_nxt;
      done_r       <= done_nxt;
      remv_r       <= remv_nxt;
      out_valid_r  <= out_valid_nxt;
      run_r        <= run_nxt;
      fin_r        <= fin_nxt;
      found_r      <= found_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    best_r     <= best_nxt;
    best_arr_r <= best_arr_nxt;
    best_bur_r <= best_bur_nxt;
    best_rem_r <= best_rem_nxt;
    run_slot_r <= run_slot_nxt;
    ft_r       <= ft_nxt;
    ta_r       <= ta_nxt;
    prod_a_r   <= prod_a_nxt;
    prod_b_r   <= prod_b_nxt;
    if (out_load) begin
      o_time_r <= 16'(cur_time_r);
      o_slot_r <= run_r ? 4'(run_slot_r) : 4'd0;
      o_idle_r <= !run_r;
      o_fin_r  <= run_r && fin_r;
      o_ft_r   <= (run_r && fin_r) ? 17'(ft_r) : 17'd0;
      o_ta_r   <= (run_r && fin_r) ? 17'(ta_r) : 17'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tick_time    = o_time_r;
  assign out_running_slot = o_slot_r;
  assign out_idle         = o_idle_r;
  assign out_finished     = o_fin_r;
  assign out_finish_time  = o_ft_r;
  assign out_turnaround   = o_ta_r;

`ifndef ASSERT_OFF
  // a finished job is never an idle tick
  a_fin_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_idle && out_finished))
    else $error("finished beat reported as idle");

  // admission never passes the table fill
  a_adm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    adm_cnt_r <= entry_cnt_r)
    else $error("admitted count beyond table entries");

  // ready queue never overfills
  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ring_cnt_r <= FULL_CNT)
    else $error("ready queue count overflow");

  // a result is loaded only in the report state
  a_out_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> state_r == ST_OUT)
    else $error("result loaded outside report state");
`endif

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cpu_process_scheduler_core: a queue-fed driver
// offers command beats in random bursts, a scoreboard predicts each tick
// result from its own model of the scheduler, and a monitor compares every
// result beat field by field while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import cps_pkg::*;

  localparam int SLOTS = 16;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] arrival;
    logic [15:0] burst;
  } cmd_beat_t;

  typedef struct packed {
    logic [15:0] tick_time;
    logic [3:0]  slot;
    logic        idle;
    logic        finished;
    logic [16:0] finish_time;
    logic [16:0] turnaround;
  } tick_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [15:0] in_arrival_time;
  logic [15:0] in_burst_time;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_tick_time;
  logic [3:0]  out_running_slot;
  logic        out_idle;
  logic        out_finished;
  logic [16:0] out_finish_time;
  logic [16:0] out_turnaround;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cmd_beat_t    pending_cmds[$];
  tick_result_t expected_ticks[$];
  int           err_count;
  int           issued;
  bit           long_hold_req;

  // scheduler shadow state
  logic [15:0] sh_arrival[SLOTS];
  logic [15:0] sh_burst[SLOTS];
  logic [15:0] sh_remaining[SLOTS];
  bit          sh_done[SLOTS];
  int          sh_ring[SLOTS];
  int          sh_head, sh_tail, sh_ring_count;
  int          sh_entries, sh_admitted;
  logic [15:0] sh_time;
  logic [15:0] sh_slice;
  int          sh_holder;
  bit          sh_holder_valid;
  logic [2:0]  sh_mode;
  logic [15:0] sh_quantum;

  cpu_process_scheduler_core u_top (.*);

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void ring_add(int s);
    if (sh_ring_count < SLOTS) begin
      sh_ring[sh_tail] = s;
      sh_tail = (sh_tail + 1) % SLOTS;
      sh_ring_count++;
    end
  endfunction

  function automatic int ring_take();
    int s;
    s = sh_ring[sh_head];
    sh_head = (sh_head + 1) % SLOTS;
    sh_ring_count--;
    return s;
  endfunction

  function automatic bit runnable(int s);
    return s < sh_admitted && !sh_done[s];
  endfunction

  function automatic void restart_sched();
    for (int i = 0; i < SLOTS; i++) begin
      sh_done[i] = 0;
      if (i < sh_entries) sh_remaining[i] = sh_burst[i];
    end
    sh_head = 0;
    sh_tail = 0;
    sh_ring_count = 0;
    sh_admitted = 0;
    sh_time = '0;
    sh_slice = '0;
    sh_holder = 0;
    sh_holder_valid = 0;
  endfunction

  // best slot by policy, lowest slot on ties
  function automatic int best_slot(logic [15:0] t);
    int best;
    longint unsigned wi, wb;
    best = -1;
    for (int i = 0; i < sh_admitted; i++) begin
      if (sh_done[i]) continue;
      if (best < 0) begin
        best = i;
        continue;
      end
      if (sh_mode == MODE_SJF) begin
        if (sh_burst[i] < sh_burst[best]) best = i;
      end else if (sh_mode == MODE_SRTF) begin
        if (sh_remaining[i] < sh_remaining[best]) best = i;
      end else if (sh_mode == MODE_HRRN) begin
        wi = (sh_arrival[i] <= t) ? t - sh_arrival[i] : 0;
        wb = (sh_arrival[best] <= t) ? t - sh_arrival[best] : 0;
        if (wi * sh_burst[best] > wb * sh_burst[i]) best = i;
      end
    end
    return best;
  endfunction

  // apply one accepted command beat and queue the tick result it causes
  function automatic void predict_beat(cmd_beat_t b);
    logic [15:0]  t;
    int           c;
    tick_result_t r;
    c = -1;
    r = '0;
    case (b.cmd)
      CMD_APPEND: begin
        if (sh_entries < SLOTS) begin
          sh_arrival[sh_entries] = b.arrival;
          sh_burst[sh_entries] = (b.burst == 0) ? 16'd1 : b.burst;
          sh_remaining[sh_entries] = sh_burst[sh_entries];
          sh_done[sh_entries] = 0;
          sh_entries++;
        end
      end
      CMD_RESTART: restart_sched();
      CMD_CLEAR: begin
        sh_entries = 0;
        restart_sched();
      end
      default: begin
        t = sh_time;
        while (sh_admitted < sh_entries && sh_arrival[sh_admitted] <= t) begin
          if (sh_mode == MODE_RR) ring_add(sh_admitted);
          sh_admitted++;
        end
        if (sh_mode == MODE_RR) begin
          if (sh_holder_valid && sh_slice == 0) begin
            ring_add(sh_holder);
            sh_holder_valid = 0;
          end
          if (sh_holder_valid && runnable(sh_holder)) c = sh_holder;
          else begin
            sh_holder_valid = 0;
            while (sh_ring_count > 0) begin
              int s;
              s = ring_take();
              if (runnable(s)) begin
                c = s;
                sh_holder = s;
                sh_holder_valid = 1;
                sh_slice = (sh_quantum == 0) ? 16'd1 : sh_quantum;
                break;
              end
            end
          end
        end else if (sh_mode == MODE_SRTF) begin
          c = best_slot(t);
        end else begin
          if (sh_holder_valid && runnable(sh_holder)) c = sh_holder;
          else begin
            sh_holder_valid = 0;
            c = best_slot(t);
            if (c >= 0) begin
              sh_holder = c;
              sh_holder_valid = 1;
            end
          end
        end
        r.tick_time = t;
        r.idle = (c < 0);
        if (c >= 0) begin
          r.slot = c[3:0];
          if (sh_remaining[c] > 0) sh_remaining[c]--;
          if (sh_slice > 0) sh_slice--;
          if (sh_remaining[c] == 0) begin
            sh_done[c] = 1;
            r.finished = 1;
            r.finish_time = {1'b0, t} + 17'd1;
            r.turnaround = r.finish_time - {1'b0, sh_arrival[c]};
            if (sh_holder == c) sh_holder_valid = 0;
            sh_slice = '0;
          end
        end
        expected_ticks = {expected_ticks, r};
        if (t != 16'hFFFF) sh_time = t + 16'd1;
      end
    endcase
  endfunction

  // sender: bursts of beats separated by random gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 5;
      gap_left <= 0;
    end else if (!(in_valid && !in_ready)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cmd_beat_t b;
        b = pending_cmds.pop_front();
        in_cmd <= b.cmd;
        in_arrival_time <= b.arrival;
        in_burst_time <= b.burst;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall pattern (ready, random, mostly stalled), plus long hold
  int rcv_cycle, hold_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rcv_cycle <= 0;
      hold_left <= 0;
    end else begin
      rcv_cycle <= rcv_cycle + 1;
      if (long_hold_req) begin
        long_hold_req = 0;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        case ((rcv_cycle / 250) % 3)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor: predict on input beats, check result beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        predict_beat('{cmd: in_cmd, arrival: in_arrival_time, burst: in_burst_time});
      if (out_valid && out_ready) begin
        if (expected_ticks.size() == 0) begin
          $error("result beat with nothing expected (tick_time %0d)", out_tick_time);
          err_count++;
        end else begin
          tick_result_t e;
          e = expected_ticks.pop_front();
          if (out_tick_time !== e.tick_time) begin
            $error("tick_time exp %0d got %0d", e.tick_time, out_tick_time);
            err_count++;
          end
          if (out_running_slot !== e.slot) begin
            $error("running_slot exp %0d got %0d", e.slot, out_running_slot);
            err_count++;
          end
          if (out_idle !== e.idle) begin
            $error("idle exp %0d got %0d", e.idle, out_idle);
            err_count++;
          end
          if (out_finished !== e.finished) begin
            $error("finished exp %0d got %0d", e.finished, out_finished);
            err_count++;
          end
          if (out_finish_time !== e.finish_time) begin
            $error("finish_time exp %0d got %0d", e.finish_time, out_finish_time);
            err_count++;
          end
          if (out_turnaround !== e.turnaround) begin
            $error("turnaround exp %0d got %0d", e.turnaround, out_turnaround);
            err_count++;
          end
        end
      end
    end
  end

  task automatic add_cmd(logic [1:0] cmd, logic [15:0] arr = '0, logic [15:0] bur = '0);
    cmd_beat_t nb;
    nb = '{cmd: cmd, arrival: arr, burst: bur};
    pending_cmds = {pending_cmds, nb};
    issued++;
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_cmds.size() > 0 || in_valid || expected_ticks.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == REG_MODE) sh_mode = data[2:0];
    else sh_quantum = data[15:0];
  endtask

  // one job set: clear or restart, appends, then ticks (capped burst total plus 2 to 10)
  task automatic job_set(bit split_mode);
    int n, ticks, total;
    logic [15:0] arr, bur;
    if ($urandom_range(0, 4) == 0) add_cmd(CMD_RESTART, $urandom(), $urandom());
    else add_cmd(CMD_CLEAR, $urandom(), $urandom());
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 18) : $urandom_range(1, 8);
    arr = $urandom_range(0, 3);
    total = 0;
    for (int i = 0; i < n; i++) begin
      // mostly sorted arrivals, rarely one out of order or full range
      if ($urandom_range(0, 19) == 0) arr = $urandom();
      else if ($urandom_range(0, 9) == 0) arr = arr - $urandom_range(1, 3);
      else arr = arr + $urandom_range(0, 3);
      if ($urandom_range(0, 29) == 0) bur = $urandom();
      else bur = $urandom_range(0, 6);
      add_cmd(CMD_APPEND, arr, bur);
      total += (bur == 0) ? 1 : ((bur > 8) ? 8 : bur);
    end
    ticks = total + $urandom_range(2, 10);
    for (int i = 0; i < ticks; i++) begin
      if (split_mode && i == ticks / 2) begin
        wait_quiet();
        reg_write({REG_MODE, 2'b00}, $urandom_range(0, 4));
      end
      add_cmd(CMD_TICK, $urandom(), $urandom());
    end
  endtask

  initial begin
    logic [15:0] qv;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_APPEND;
    in_arrival_time = '0;
    in_burst_time = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    err_count = 0;
    issued = 0;
    long_hold_req = 0;
    sh_mode = MODE_FCFS;
    sh_quantum = 16'd1;
    sh_entries = 0;
    restart_sched();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fcfs start, zero burst, out of order hold-back, extremes
    add_cmd(CMD_CLEAR);
    add_cmd(CMD_APPEND, 16'd3, 16'd2);
    add_cmd(CMD_APPEND, 16'd3, 16'd0);
    add_cmd(CMD_APPEND, 16'd0, 16'd1);
    add_cmd(CMD_APPEND, 16'hFFFF, 16'hFFFF);
    add_cmd(CMD_APPEND, 16'd1, 16'd1);
    repeat (8) add_cmd(CMD_TICK);
    add_cmd(CMD_RESTART);
    repeat (3) add_cmd(CMD_TICK);
    add_cmd(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
    add_cmd(CMD_APPEND, 16'd0, 16'd2);
    add_cmd(CMD_APPEND, 16'd0, 16'd1);
    repeat (4) add_cmd(CMD_TICK);
    wait_quiet();

    // random job sets over all policies and quantum extremes
    while (issued < 800) begin
      if ($urandom_range(0, 5) == 0) reg_write({REG_MODE, 2'b00}, $urandom_range(5, 7));
      else reg_write({REG_MODE, 2'b00}, $urandom_range(0, 4));
      case ($urandom_range(0, 5))
        0: qv = 16'd0;
        1: qv = 16'hFFFF;
        default: qv = $urandom_range(1, 4);
      endcase
      reg_write({REG_QUANTUM, 2'b00}, {16'd0, qv});
      if (issued > 300 && issued < 330) long_hold_req = 1;
      job_set($urandom_range(0, 5) == 0);
      wait_quiet();
    end
    // one long hold while the sender keeps offering ticks
    long_hold_req = 1;
    job_set(0);
    wait_quiet();
    repeat (50) @(posedge clk);

    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
src/cps_pkg.sv
src/cps_tables.sv
src/cpu_process_scheduler_core.sv
bench/testbench.sv
